// ----- src/mcfl_pkg.sv -----
`timescale 1ns / 1ps

package mcfl_pkg;

  localparam int QUEUE_DEPTH = 128;
  localparam int FRAME_BYTES = 12;
  localparam int BODY_BYTES  = FRAME_BYTES - 1;
  localparam int FRAME_W     = 8 * BODY_BYTES;
  localparam int MAX_PAYLOAD = 9;
  localparam int JQ_DEPTH    = 4;
  localparam logic [7:0] FILL_BYTE = 8'hFF;

  typedef enum logic [1:0] {
    KIND_TX      = 2'd0,
    KIND_VERDICT = 2'd1,
    KIND_REFUSE  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    VERDICT_ACCEPTED    = 3'd0,
    VERDICT_UNSOLICITED = 3'd1,
    VERDICT_BAD_CHECKSUM = 3'd2,
    VERDICT_BAD_OPCODE  = 3'd3,
    VERDICT_BAD_SEQUENCE = 3'd4
  } verdict_t;

  // one unit of work for the output sequencer
  // data holds frame bytes 0..10 (tx) or reply bytes 0..10 (verdict), byte 0 lsb
  typedef struct packed {
    kind_t                kind;
    verdict_t             verdict;
    logic                 last;
    logic [FRAME_W-1:0]   data;
  } job_t;

endpackage

// ----- src/mcfl_ifs.sv -----
`timescale 1ns / 1ps

interface mcfl_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  command_opcode;
  logic [3:0]  payload_length;
  logic [63:0] payload_low;
  logic [7:0]  payload_byte_ten;
  logic [7:0]  rx_byte;

  modport source (
    output valid, op, command_opcode, payload_length, payload_low, payload_byte_ten,
           rx_byte,
    input  ready
  );
  modport sink (
    input  valid, op, command_opcode, payload_length, payload_low, payload_byte_ten,
           rx_byte,
    output ready
  );
endinterface

interface mcfl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  tx_byte;
  logic [2:0]  verdict;
  logic [7:0]  reply_opcode;
  logic [63:0] reply_payload_low;
  logic [7:0]  reply_byte_ten;
  logic        last;

  modport source (
    output valid, kind, tx_byte, verdict, reply_opcode, reply_payload_low,
           reply_byte_ten, last,
    input  ready
  );
  modport sink (
    input  valid, kind, tx_byte, verdict, reply_opcode, reply_payload_low,
           reply_byte_ten, last,
    output ready
  );
endinterface

// ----- src/mcfl_ram.sv -----
`timescale 1ns / 1ps

module mcfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/mcfl_front.sv -----
`timescale 1ns / 1ps

module mcfl_front #(
  parameter int QUEUE_DEPTH = mcfl_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  mcfl_in_if.sink          in_ch,
  output logic             push,
  output mcfl_pkg::job_t   push_job,
  input  logic             jq_room
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int FW    = mcfl_pkg::FRAME_W;
  localparam int NB    = mcfl_pkg::BODY_BYTES;

  typedef enum logic {
    ST_RUN,
    ST_LOAD
  } state_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  state_t             state_r, state_nxt;
  logic [7:0]         seq_r, seq_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [OCC_W-1:0]   occ_r, occ_nxt;
  logic [3:0]         rx_cnt_r, rx_cnt_nxt;
  logic [7:0]         rx_sum_r, rx_sum_nxt;
  logic [7:0]         rx_bytes_r [NB];
  logic [15:0]        head_id_r, head_id_nxt;

  logic               accept, is_enq, is_rx, q_full, q_empty, rx_done;
  logic               rx_store, head_load, ram_we;
  logic [3:0]         len_sat;
  logic [7:0]         seq_plus;
  logic [71:0]        pay_all;
  logic [FW-1:0]      new_frame, reply_data, ram_rdata;
  mcfl_pkg::verdict_t verdict;

  // frame store: bytes 0..10 of every pending frame
  mcfl_ram #(
    .WIDTH(FW),
    .DEPTH(QUEUE_DEPTH)
  ) u_frame_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(wr_ptr_r),
    .wr_data(new_frame),
    .rd_addr(rd_ptr_nxt),
    .rd_data(ram_rdata)
  );

  assign in_ch.ready = (state_r == ST_RUN) && jq_room;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_enq      = accept && !in_ch.op;
  assign is_rx       = accept && in_ch.op;
  assign q_full      = (occ_r == OCC_W'(QUEUE_DEPTH));
  assign q_empty     = (occ_r == '0);
  assign rx_done     = (rx_cnt_r == 4'(NB));
  assign seq_plus    = seq_r + 8'd1;
  assign pay_all     = {in_ch.payload_byte_ten, in_ch.payload_low};
  assign len_sat     = (in_ch.payload_length > 4'(mcfl_pkg::MAX_PAYLOAD)) ?
                       4'(mcfl_pkg::MAX_PAYLOAD) : in_ch.payload_length;

  // frame build, unused payload bytes filled
  always_comb begin
    new_frame[7:0]  = in_ch.command_opcode;
    new_frame[15:8] = seq_plus;
    for (int i = 0; i < mcfl_pkg::MAX_PAYLOAD; i++) begin
      new_frame[16 + 8*i +: 8] = (4'(i) < len_sat) ? pay_all[8*i +: 8] :
                                 mcfl_pkg::FILL_BYTE;
    end
  end

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      reply_data[8*i +: 8] = rx_bytes_r[i];
    end
  end

  // empty queue first, then checksum, then opcode, then sequence
  always_comb begin
    priority if (q_empty) begin
      verdict = mcfl_pkg::VERDICT_UNSOLICITED;
    end else if (in_ch.rx_byte != rx_sum_r) begin
      verdict = mcfl_pkg::VERDICT_BAD_CHECKSUM;
    end else if (rx_bytes_r[0] != head_id_r[7:0]) begin
      verdict = mcfl_pkg::VERDICT_BAD_OPCODE;
    end else if (rx_bytes_r[1] != head_id_r[15:8]) begin
      verdict = mcfl_pkg::VERDICT_BAD_SEQUENCE;
    end else begin
      verdict = mcfl_pkg::VERDICT_ACCEPTED;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    seq_nxt     = seq_r;
    rd_ptr_nxt  = rd_ptr_r;
    wr_ptr_nxt  = wr_ptr_r;
    occ_nxt     = occ_r;
    rx_cnt_nxt  = rx_cnt_r;
    rx_sum_nxt  = rx_sum_r;
    rx_store    = 1'b0;
    head_load   = 1'b0;
    head_id_nxt = new_frame[15:0];
    ram_we      = 1'b0;
    push        = 1'b0;
    push_job.kind    = mcfl_pkg::KIND_TX;
    push_job.verdict = mcfl_pkg::VERDICT_ACCEPTED;
    push_job.last    = 1'b1;
    push_job.data    = new_frame;

    unique case (state_r)
      ST_RUN: begin
        if (is_enq) begin
          if (q_full) begin
            push          = 1'b1;
            push_job.kind = mcfl_pkg::KIND_REFUSE;
            push_job.data = '0;
          end else begin
            ram_we     = 1'b1;
            seq_nxt    = seq_plus;
            wr_ptr_nxt = ptr_next(wr_ptr_r);
            occ_nxt    = occ_r + 1'b1;
            if (q_empty) begin
              push      = 1'b1;
              head_load = 1'b1;
            end
          end
        end else if (is_rx) begin
          if (!rx_done) begin
            rx_store   = 1'b1;
            rx_sum_nxt = rx_sum_r + in_ch.rx_byte;
            rx_cnt_nxt = rx_cnt_r + 4'd1;
          end else begin
            push             = 1'b1;
            push_job.kind    = mcfl_pkg::KIND_VERDICT;
            push_job.verdict = verdict;
            push_job.data    = reply_data;
            rx_cnt_nxt       = '0;
            rx_sum_nxt       = '0;
            if (!q_empty) begin
              rd_ptr_nxt = ptr_next(rd_ptr_r);
              occ_nxt    = occ_r - 1'b1;
              // another frame waits: fetch it as the new head
              if (occ_r > OCC_W'(1)) begin
                push_job.last = 1'b0;
                state_nxt     = ST_LOAD;
              end
            end
          end
        end
      end
      ST_LOAD: begin
        head_id_nxt = ram_rdata[15:0];
        if (jq_room) begin
          push          = 1'b1;
          push_job.data = ram_rdata;
          head_load     = 1'b1;
          state_nxt     = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_RUN;
      seq_r    <= '0;
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      occ_r    <= '0;
      rx_cnt_r <= '0;
      rx_sum_r <= '0;
    end else begin
      state_r  <= state_nxt;
      seq_r    <= seq_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      occ_r    <= occ_nxt;
      rx_cnt_r <= rx_cnt_nxt;
      rx_sum_r <= rx_sum_nxt;
    end
    if (rx_store) begin
      rx_bytes_r[rx_cnt_r] <= in_ch.rx_byte;
    end
    if (head_load) begin
      head_id_r <= head_id_nxt;
    end
  end

endmodule

// ----- src/mcfl_jobq.sv -----
`timescale 1ns / 1ps

module mcfl_jobq #(
  parameter int DEPTH = mcfl_pkg::JQ_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mcfl_pkg::job_t  push_job,
  output logic            room,
  input  logic            pop,
  output mcfl_pkg::job_t  pop_job,
  output logic            not_empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  mcfl_pkg::job_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign room      = (cnt_r != CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ----- src/mcfl_back.sv -----
`timescale 1ns / 1ps

module mcfl_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            job_valid,
  input  mcfl_pkg::job_t  job,
  output logic            pop,
  mcfl_out_if.source      out_ch
);

  localparam int NB = mcfl_pkg::BODY_BYTES;

  mcfl_pkg::job_t     cur_r;
  logic               cur_valid_r, cur_valid_nxt;
  logic [3:0]         idx_r, idx_nxt;
  logic [7:0]         sum_r, sum_nxt;

  logic               out_valid_r, out_valid_nxt;
  mcfl_pkg::kind_t    out_kind_r;
  logic [7:0]         out_tx_r;
  mcfl_pkg::verdict_t out_verdict_r;
  logic [7:0]         out_rop_r;
  logic [63:0]        out_rpl_r;
  logic [7:0]         out_rten_r;
  logic               out_last_r;

  logic               can_load, emit, is_tx, tx_final, cur_done;
  logic [7:0]         data_byte, tx_byte;

  assign can_load = !out_valid_r || out_ch.ready;
  assign emit     = cur_valid_r && can_load;
  assign is_tx    = (cur_r.kind == mcfl_pkg::KIND_TX);
  assign tx_final = (idx_r == 4'(NB));
  assign cur_done = emit && (!is_tx || tx_final);
  assign pop      = job_valid && (!cur_valid_r || cur_done);

  always_comb begin
    data_byte = '0;
    for (int i = 0; i < NB; i++) begin
      if (idx_r == 4'(i)) begin
        data_byte = cur_r.data[8*i +: 8];
      end
    end
  end

  // trailing byte is the running sum of the eleven before it
  assign tx_byte = tx_final ? sum_r : data_byte;

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    sum_nxt       = sum_r;
    if (pop) begin
      cur_valid_nxt = 1'b1;
      idx_nxt       = '0;
      sum_nxt       = '0;
    end else if (cur_done) begin
      cur_valid_nxt = 1'b0;
    end else if (emit) begin
      idx_nxt = idx_r + 4'd1;
      sum_nxt = sum_r + data_byte;
    end
    out_valid_nxt = emit ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      sum_r       <= '0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      sum_r       <= sum_nxt;
    end
    if (pop) begin
      cur_r <= job;
    end
    if (emit) begin
      out_kind_r    <= cur_r.kind;
      out_tx_r      <= '0;
      out_verdict_r <= mcfl_pkg::VERDICT_ACCEPTED;
      out_rop_r     <= '0;
      out_rpl_r     <= '0;
      out_rten_r    <= '0;
      out_last_r    <= cur_r.last;
      unique case (cur_r.kind)
        mcfl_pkg::KIND_TX: begin
          out_tx_r   <= tx_byte;
          out_last_r <= tx_final;
        end
        mcfl_pkg::KIND_VERDICT: begin
          out_verdict_r <= cur_r.verdict;
          out_rop_r     <= cur_r.data[7:0];
          out_rpl_r     <= cur_r.data[79:16];
          out_rten_r    <= cur_r.data[87:80];
        end
        mcfl_pkg::KIND_REFUSE: begin
          out_last_r <= 1'b1;
        end
        default: begin
          out_last_r <= 1'b1;
        end
      endcase
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.kind              = out_kind_r;
  assign out_ch.tx_byte           = out_tx_r;
  assign out_ch.verdict           = out_verdict_r;
  assign out_ch.reply_opcode      = out_rop_r;
  assign out_ch.reply_payload_low = out_rpl_r;
  assign out_ch.reply_byte_ten    = out_rten_r;
  assign out_ch.last              = out_last_r;

endmodule

// ----- src/mcu_command_frame_link_top.sv -----
`timescale 1ns / 1ps

// channel   dir  handshake       word
// in_ch     in   valid / ready   enqueue command (op 0) or one received reply byte (op 1)
// out_ch    out  valid / ready   transmit byte, reply verdict or queue-full refusal
//
// input words are taken one a cycle, back to back while the job queue has room
// a reply byte that completes a frame with another command waiting holds ready low
//   while the new head is read from the frame ram
// out_ch gives one word a cycle while ready is high: a frame is 12 words, a verdict plus the next frame 13
// reset is synchronous, the frame ram needs no clearing
// 4-entry job queue between the sides, input stalls while it is full and while a new head is read

module mcu_command_frame_link_top #(
  parameter int QUEUE_DEPTH = mcfl_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  mcfl_in_if.sink     in_ch,
  mcfl_out_if.source  out_ch
);

  // front -> job queue
  logic           push;
  mcfl_pkg::job_t push_job;
  logic           jq_room;

  // job queue -> output sequencer
  logic           pop;
  mcfl_pkg::job_t pop_job;
  logic           jq_not_empty;

  // front: builds frames, keeps the frame queue, assembles and judges replies
  mcfl_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .push    (push),
    .push_job(push_job),
    .jq_room (jq_room)
  );

  // short queue of pending output jobs
  mcfl_jobq #(
    .DEPTH(mcfl_pkg::JQ_DEPTH)
  ) u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .room     (jq_room),
    .pop      (pop),
    .pop_job  (pop_job),
    .not_empty(jq_not_empty)
  );

  // back: serializes frames with their checksum, emits verdicts and refusals
  mcfl_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_valid(jq_not_empty),
    .job      (pop_job),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

// ----- src/mcfl_checker.sv -----
`timescale 1ns / 1ps

module mcfl_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_tx_byte,
  input logic       out_last
);

  logic       fire, fire_tx;
  logic [3:0] tx_cnt_r;
  logic [7:0] tx_sum_r;
  logic       expect_tx_r;

  assign fire    = out_valid && out_ready;
  assign fire_tx = fire && (out_kind == mcfl_pkg::KIND_TX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_cnt_r    <= '0;
      tx_sum_r    <= '0;
      expect_tx_r <= 1'b0;
    end else begin
      if (fire_tx) begin
        tx_cnt_r    <= out_last ? 4'd0 : tx_cnt_r + 4'd1;
        tx_sum_r    <= out_last ? 8'd0 : tx_sum_r + out_tx_byte;
        expect_tx_r <= 1'b0;
      end else if (fire && (out_kind == mcfl_pkg::KIND_VERDICT) && !out_last) begin
        expect_tx_r <= 1'b1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
                                $stable(out_tx_byte) && $stable(out_last))
    else $error("output word changed while stalled");

  a_frame_len: assert property (@(posedge clk) disable iff (!rst_n)
    fire_tx |-> (out_last == (tx_cnt_r == 4'(mcfl_pkg::BODY_BYTES))))
    else $error("transmit frame not twelve bytes");

  a_frame_sum: assert property (@(posedge clk) disable iff (!rst_n)
    fire_tx && out_last |-> (out_tx_byte == tx_sum_r))
    else $error("frame checksum byte wrong");

  a_next_frame: assert property (@(posedge clk) disable iff (!rst_n)
    fire && expect_tx_r |-> (out_kind == mcfl_pkg::KIND_TX))
    else $error("verdict without last not followed by a frame");

endmodule

bind mcu_command_frame_link_top mcfl_checker u_mcfl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_kind   (out_ch.kind),
  .out_tx_byte(out_ch.tx_byte),
  .out_last   (out_ch.last)
);
